/* hdl/swtf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swtf_pkg
// shared constants for the stop word trace filter
// ----------------------------------------------------------------------------
package swtf_pkg;

    localparam int ID_BITS_DEF       = 16;
    localparam int PENDING_DEPTH_DEF = 16;
    localparam int REPORT_BITS_DEF   = 16;

    // input command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_ELEM  = 1'b1;

    // configuration register indexes
    localparam logic CFG_TRIM_ENDS = 1'b0;
    localparam logic CFG_ENABLE    = 1'b1;

endpackage
`default_nettype wire

/* hdl/swtf_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swtf_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module swtf_ram
    import swtf_pkg::*;
#(
    parameter int WIDTH     = 16,
    parameter int ADDR_BITS = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [ADDR_BITS-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]     i_wdata,
    input  wire logic                 i_re,
    input  wire logic [ADDR_BITS-1:0] i_raddr,
    output logic      [WIDTH-1:0]     o_rdata
);

    logic [WIDTH-1:0] r_mem [2**ADDR_BITS];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

/* hdl/stop_word_trace_filter.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stop_word_trace_filter
// filters stack trace elements against a stop word bit table held in ram
// ----------------------------------------------------------------------------
// sequence: a table write is taken in S_IDLE; an element reads the table ram
//   (S_LOOK), then sends the held id (S_HELD) and each released pending id
//   (S_FRD pending ram read, S_FWR), with S_LAST on the last element of a stack
// throughput: one element in flight at a time; output back-pressure adds stalls
// reset: control state cleared; table and pending ram contents undefined until
//   written, no clearing pass
module stop_word_trace_filter
    import swtf_pkg::*;
#(
    parameter int ID_BITS       = ID_BITS_DEF,
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF,
    parameter int REPORT_BITS   = REPORT_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // element and table write channel
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic                   i_cmd,
    input  wire logic [ID_BITS-1:0]     i_function_id,
    input  wire logic                   i_stop_mark,
    input  wire logic [REPORT_BITS-1:0] i_report_id,
    input  wire logic                   i_last_in,
    // result channel
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic      [ID_BITS-1:0]     o_kept_id,
    output logic      [REPORT_BITS-1:0] o_kept_report,
    output logic                        o_last_out,
    output logic                        o_overflow,
    // configuration channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic                   i_cfg_index,
    input  wire logic                   i_cfg_data
);

    localparam int CW  = $clog2(PENDING_DEPTH + 1);
    localparam int PAW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam logic [CW-1:0] PEND_FULL = CW'(PENDING_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_HELD,
        S_FRD,
        S_FWR,
        S_LAST
    } t_state;

    t_state                 r_state;
    logic                   r_trim;
    logic                   r_enable;
    logic [ID_BITS-1:0]     r_id;
    logic [REPORT_BITS-1:0] r_rep;
    logic                   r_last;
    logic [ID_BITS-1:0]     r_held_id;
    logic [REPORT_BITS-1:0] r_held_rep;
    logic                   r_held_valid;
    logic                   r_ovf_seen;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          r_idx;
    logic                   r_out_valid;
    logic [ID_BITS-1:0]     r_out_id;
    logic [REPORT_BITS-1:0] r_out_rep;
    logic                   r_out_last;
    logic                   r_out_ovf;

    logic                   in_xfer;
    logic                   out_free;
    logic                   out_load;
    logic                   table_rdata;
    logic                   stop;
    logic                   pend_we;
    logic [ID_BITS-1:0]     pend_rdata;
    logic [CW-1:0]          n_idx;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    // states that place a result in the output register this cycle
    assign out_load    = out_free && ((r_state == S_HELD) || (r_state == S_FWR)
                         || ((r_state == S_LAST) && r_held_valid));
    assign stop        = r_enable && table_rdata;
    assign pend_we     = (r_state == S_LOOK) && stop && r_trim && r_held_valid
                         && (r_count < PEND_FULL);
    assign n_idx       = r_idx + CW'(1);

    swtf_ram #(
        .WIDTH     (1),
        .ADDR_BITS (ID_BITS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (in_xfer && (i_cmd == CMD_WRITE)),
        .i_waddr (i_function_id),
        .i_wdata (i_stop_mark),
        .i_re    (in_xfer && (i_cmd == CMD_ELEM)),
        .i_raddr (i_function_id),
        .o_rdata (table_rdata)
    );

    swtf_ram #(
        .WIDTH     (ID_BITS),
        .ADDR_BITS (PAW)
    ) u_pending (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (r_count[PAW-1:0]),
        .i_wdata (r_id),
        .i_re    (r_state == S_FRD),
        .i_raddr (r_idx[PAW-1:0]),
        .o_rdata (pend_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_trim       <= 1'b0;
            r_enable     <= 1'b0;
            r_held_id    <= '0;
            r_held_rep   <= '0;
            r_held_valid <= 1'b0;
            r_ovf_seen   <= 1'b0;
            r_count      <= '0;
            r_idx        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_TRIM_ENDS: r_trim   <= i_cfg_data;
                    CFG_ENABLE:    r_enable <= i_cfg_data;
                    default:       ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && (i_cmd == CMD_ELEM)) begin
                        r_id    <= i_function_id;
                        r_rep   <= i_report_id;
                        r_last  <= i_last_in;
                        r_state <= S_LOOK;
                    end
                end
                S_LOOK: begin
                    if (stop) begin
                        if (r_trim && r_held_valid) begin
                            if (r_count < PEND_FULL) begin
                                r_count <= r_count + CW'(1);
                            end else begin
                                r_ovf_seen <= 1'b1;
                            end
                        end
                        r_state <= r_last ? S_LAST : S_IDLE;
                    end else if (r_held_valid) begin
                        r_state <= S_HELD;
                    end else begin
                        // first kept id of the stack
                        r_held_id    <= r_id;
                        r_held_rep   <= r_rep;
                        r_held_valid <= 1'b1;
                        r_state      <= r_last ? S_LAST : S_IDLE;
                    end
                end
                S_HELD: begin
                    if (out_free) begin
                        r_out_id    <= r_held_id;
                        r_out_rep   <= r_held_rep;
                        r_out_last  <= 1'b0;
                        r_out_ovf   <= 1'b0;
                        if (r_count != '0) begin
                            r_idx   <= '0;
                            r_state <= S_FRD;
                        end else begin
                            r_held_id  <= r_id;
                            r_held_rep <= r_rep;
                            r_state    <= r_last ? S_LAST : S_IDLE;
                        end
                    end
                end
                S_FRD: begin
                    r_state <= S_FWR;
                end
                S_FWR: begin
                    if (out_free) begin
                        // released pending ids take the releasing element's report
                        r_out_id    <= pend_rdata;
                        r_out_rep   <= r_rep;
                        r_out_last  <= 1'b0;
                        r_out_ovf   <= 1'b0;
                        r_idx       <= n_idx;
                        if (n_idx == r_count) begin
                            r_count    <= '0;
                            r_held_id  <= r_id;
                            r_held_rep <= r_rep;
                            r_state    <= r_last ? S_LAST : S_IDLE;
                        end else begin
                            r_state <= S_FRD;
                        end
                    end
                end
                S_LAST: begin
                    if (!r_held_valid || out_free) begin
                        if (r_held_valid) begin
                            r_out_id    <= r_held_id;
                            r_out_rep   <= r_held_rep;
                            r_out_last  <= 1'b1;
                            r_out_ovf   <= r_ovf_seen;
                        end
                        // trailing pending ids are discarded
                        r_held_id    <= '0;
                        r_held_rep   <= '0;
                        r_held_valid <= 1'b0;
                        r_ovf_seen   <= 1'b0;
                        r_count      <= '0;
                        r_state      <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_kept_id     = r_out_id;
    assign o_kept_report = r_out_rep;
    assign o_last_out    = r_out_last;
    assign o_overflow    = r_out_ovf;

endmodule
`default_nettype wire

/* test/stop_word_trace_filter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stop_word_trace_filter_test
// loads the stop table and runs directed stacks through every filter mode,
// then random stacks with random idling on the element and result channels;
// each result transfer is checked against a bench-side copy of the filter
// ----------------------------------------------------------------------------
module stop_word_trace_filter_test;
    import swtf_pkg::*;

    localparam int IDW          = ID_BITS_DEF;
    localparam int RPW          = REPORT_BITS_DEF;
    localparam int DEPTH        = PENDING_DEPTH_DEF;
    localparam int QUIET_CYCLES = 40;
    localparam int STALL_LIMIT  = 3000;
    localparam int ELEM_TARGET  = 140;
    localparam int MAX_SHOWN    = 10;

    // fixed ids for the directed stacks
    localparam logic [IDW-1:0] STOP_A = 16'h0000;
    localparam logic [IDW-1:0] KEEP_A = 16'hFFFF;
    localparam logic [IDW-1:0] STOP_B = 16'h5A5A;
    localparam logic [IDW-1:0] KEEP_B = 16'hA5A5;

    typedef struct packed {
        logic [IDW-1:0] fid;
        logic [RPW-1:0] report;
        logic           last;
        logic           ovf;
    } t_kept;

    typedef enum {PICK_PLAIN, PICK_STOP, PICK_ANY} t_pick;

    logic           i_clk         = 1'b0;
    logic           i_rst_n       = 1'b0;
    logic           i_in_valid    = 1'b0;
    logic           i_cmd         = 1'b0;
    logic [IDW-1:0] i_function_id = '0;
    logic           i_stop_mark   = 1'b0;
    logic [RPW-1:0] i_report_id   = '0;
    logic           i_last_in     = 1'b0;
    logic           i_out_ready   = 1'b0;
    logic           i_cfg_valid   = 1'b0;
    logic           i_cfg_index   = 1'b0;
    logic           i_cfg_data    = 1'b0;
    logic           o_in_ready;
    logic           o_out_valid;
    logic [IDW-1:0] o_kept_id;
    logic [RPW-1:0] o_kept_report;
    logic           o_last_out;
    logic           o_overflow;
    logic           o_cfg_ready;

    // filter state as the bench sees it
    bit             stop_bits [1 << IDW];
    bit             loaded    [1 << IDW];
    logic [IDW-1:0] loaded_ids[$];
    logic [IDW-1:0] pend_q[$];
    logic [IDW-1:0] held_fid  = '0;
    logic [RPW-1:0] held_rep  = '0;
    bit             held_ok   = 1'b0;
    bit             ovf_seen  = 1'b0;
    bit             trim_mode = 1'b0;
    bit             filt_on   = 1'b0;
    t_kept          kept_q[$];

    int mismatches = 0;
    int elems_sent = 0;
    int sink_stall = 0;
    bit steady     = 1'b0;

    stop_word_trace_filter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_cmd        (i_cmd),
        .i_function_id(i_function_id),
        .i_stop_mark  (i_stop_mark),
        .i_report_id  (i_report_id),
        .i_last_in    (i_last_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_kept_id    (o_kept_id),
        .o_kept_report(o_kept_report),
        .o_last_out   (o_last_out),
        .o_overflow   (o_overflow),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void queue_kept(t_kept k);
        kept_q = {kept_q, k};
    endfunction

    // expected results of one accepted transfer on the element channel
    function automatic void predict_filter(logic cmd, logic [IDW-1:0] fid, logic mark,
                                           logic [RPW-1:0] rep, logic last);
        bit is_stop;
        if (cmd == CMD_WRITE) begin
            stop_bits[fid] = mark;
            if (!loaded[fid]) begin
                loaded[fid] = 1'b1;
                loaded_ids  = {loaded_ids, fid};
            end
            return;
        end
        is_stop = filt_on && stop_bits[fid];
        if (is_stop) begin
            if (trim_mode && held_ok) begin
                if (pend_q.size() < DEPTH)
                    pend_q = {pend_q, fid};
                else
                    ovf_seen = 1'b1;
            end
        end else begin
            if (held_ok)
                queue_kept(t_kept'{held_fid, held_rep, 1'b0, 1'b0});
            // released interior words travel with the releasing report
            foreach (pend_q[k])
                queue_kept(t_kept'{pend_q[k], rep, 1'b0, 1'b0});
            pend_q.delete();
            held_fid = fid;
            held_rep = rep;
            held_ok  = 1'b1;
        end
        if (last) begin
            if (held_ok)
                queue_kept(t_kept'{held_fid, held_rep, 1'b1, ovf_seen});
            pend_q.delete();
            held_fid = '0;
            held_rep = '0;
            held_ok  = 1'b0;
            ovf_seen = 1'b0;
        end
    endfunction

    // only ids whose table bit has been written are ever sent as elements
    function automatic logic [IDW-1:0] pick_id(t_pick want);
        logic [IDW-1:0] cand;
        cand = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
        for (int t = 0; t < 32; t++) begin
            if (want == PICK_ANY || stop_bits[cand] == (want == PICK_STOP)) return cand;
            cand = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
        end
        return cand;
    endfunction

    task automatic send_item(logic cmd, logic [IDW-1:0] fid, logic mark,
                             logic [RPW-1:0] rep, logic last);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_function_id <= fid;
        i_stop_mark   <= mark;
        i_report_id   <= rep;
        i_last_in     <= last;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_filter(cmd, fid, mark, rep, last);
        if (cmd == CMD_ELEM) elems_sent++;
    endtask

    task automatic send_write(logic [IDW-1:0] fid, logic mark);
        // report and last are don't-care on a table write
        send_item(CMD_WRITE, fid, mark, RPW'($urandom), 1'($urandom));
    endtask

    task automatic send_elem(logic [IDW-1:0] fid, logic [RPW-1:0] rep, logic last);
        send_item(CMD_ELEM, fid, 1'($urandom), rep, last);
    endtask

    // hold the sender until all results are in, then let any late work finish
    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (kept_q.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic val);
        wait_idle();
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_TRIM_ENDS)
            trim_mode = val;
        else
            filt_on = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_mode(logic trim, logic enable);
        write_reg(CFG_TRIM_ENDS, trim);
        write_reg(CFG_ENABLE, enable);
    endtask

    task automatic load_random();
        logic [IDW-1:0] fid;
        if (loaded_ids.size() < 48 || $urandom_range(0, 1))
            fid = IDW'($urandom);
        else
            fid = loaded_ids[$urandom_range(0, loaded_ids.size() - 1)];
        send_write(fid, 1'($urandom));
    endtask

    task automatic send_stack(int len, int stop_pct, bit deep);
        logic [RPW-1:0] rep;
        t_pick          want;
        rep = RPW'($urandom);
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 99) < 6) load_random();
            if ($urandom_range(0, 99) < 15) rep = RPW'($urandom);
            if (deep)
                want = (k == 0 || k == len - 1) ? PICK_PLAIN : PICK_STOP;
            else
                want = ($urandom_range(0, 99) < stop_pct) ? PICK_STOP : PICK_PLAIN;
            send_elem(pick_id(want), rep, k == len - 1);
        end
    endtask

    task automatic test_table_load();
        send_write(STOP_A, 1'b0);
        send_write(STOP_A, 1'b1);
        send_write(KEEP_A, 1'b0);
        send_write(STOP_B, 1'b1);
        send_write(KEEP_B, 1'b0);
    endtask

    // filter off after reset: stop words go straight through
    task automatic test_pass_through();
        send_elem(STOP_A, 16'h0000, 1'b0);
        send_elem(KEEP_A, 16'hFFFF, 1'b1);
    endtask

    task automatic test_remove_all();
        set_mode(1'b0, 1'b1);
        send_elem(STOP_A, 16'h0001, 1'b0);
        send_elem(KEEP_A, 16'h0002, 1'b0);
        send_elem(STOP_B, 16'h0003, 1'b0);
        send_elem(KEEP_B, 16'hFFFF, 1'b1);
        // stack of stop words only gives nothing
        send_elem(STOP_A, 16'h0000, 1'b1);
    endtask

    task automatic test_trim_ends();
        set_mode(1'b1, 1'b1);
        send_elem(STOP_A, 16'h0001, 1'b0);
        send_elem(KEEP_A, 16'h0002, 1'b0);
        send_elem(STOP_B, 16'h0003, 1'b0);
        send_elem(STOP_A, 16'h0004, 1'b0);
        send_elem(KEEP_B, 16'h0005, 1'b0);
        send_elem(STOP_B, 16'h0006, 1'b1);
    endtask

    // registers change with a stack open; the pending word is still released
    task automatic test_mode_switch();
        send_elem(KEEP_A, 16'h0011, 1'b0);
        send_elem(STOP_B, 16'h0012, 1'b0);
        set_mode(1'b0, 1'b1);
        send_elem(STOP_A, 16'h0013, 1'b0);
        send_elem(KEEP_B, 16'h0014, 1'b1);
    endtask

    // pending store fills, then the stack ends on stop words
    task automatic test_pending_overflow();
        set_mode(1'b1, 1'b1);
        steady = 1'b1;
        send_elem(KEEP_A, 16'h0021, 1'b0);
        for (int k = 0; k <= DEPTH; k++)
            send_elem(k[0] ? STOP_B : STOP_A, 16'h0022, k == DEPTH);
        steady = 1'b0;
    endtask

    task automatic test_random_stacks();
        int phase;
        int goal;
        int r;
        phase = 0;
        goal  = elems_sent + ELEM_TARGET;
        while (elems_sent < goal) begin
            case (phase)
                0:       set_mode(1'b1, 1'b1);
                1:       set_mode(1'b0, 1'b1);
                2:       set_mode(1'b1, 1'b0);
                3:       set_mode(1'b0, 1'b0);
                default: set_mode(1'($urandom), $urandom_range(0, 3) != 0);
            endcase
            steady = (phase % 3 == 2);
            repeat ($urandom_range(1, 4)) load_random();
            repeat ($urandom_range(3, 6)) begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    send_stack($urandom_range(DEPTH, DEPTH + 5), 0, 1'b1);
                else if (r < 22)
                    send_stack($urandom_range(1, 4), 100, 1'b0);
                else
                    send_stack($urandom_range(1, 8), $urandom_range(20, 70), 1'b0);
                if (phase == 1 && r < 40) wait_idle();
            end
            phase++;
        end
        steady = 1'b0;
    endtask

    always @(negedge i_clk) begin : result_sink
        if (sink_stall > 0) begin
            i_out_ready <= 1'b0;
            sink_stall--;
        end else begin
            i_out_ready <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    always @(posedge i_clk) begin : result_check
        t_kept got;
        t_kept want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got = t_kept'{o_kept_id, o_kept_report, o_last_out, o_overflow};
            if (kept_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_SHOWN)
                    $display("unexpected result: id %h report %h last %b ovf %b",
                             got.fid, got.report, got.last, got.ovf);
            end else begin
                want = kept_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("mismatch: exp %h %h %b %b got %h %h %b %b",
                                 want.fid, want.report, want.last, want.ovf,
                                 got.fid, got.report, got.last, got.ovf);
                end
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)
                    || (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[stop_word_trace_filter] ERROR");
        $finish;
    end

    initial begin
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_table_load();
        test_pass_through();
        test_remove_all();
        test_trim_ends();
        test_mode_switch();
        test_pending_overflow();
        test_random_stacks();

        wait_idle();
        if (mismatches == 0 && kept_q.size() == 0) begin
            $display("[stop_word_trace_filter] OK");
        end else begin
            $display("[stop_word_trace_filter] ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
hdl/swtf_pkg.sv
hdl/swtf_ram.sv
hdl/stop_word_trace_filter.sv
test/stop_word_trace_filter_test.sv
